>>> design/cursor_line_edit_buffer_macros.svh
// ----------------------------------------------------------------------------
// cursor_line_edit_buffer_macros
// Assertion macros used by the line-edit buffer top level.
// ----------------------------------------------------------------------------
`ifndef CURSOR_LINE_EDIT_BUFFER_MACROS_SVH
`define CURSOR_LINE_EDIT_BUFFER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define CLEB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define CLEB_ASSERT_NEVER(lbl, cond, msg) \
  `CLEB_ASSERT(lbl, !(cond), msg)
`else
`define CLEB_ASSERT(lbl, prop, msg)
`define CLEB_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

>>> design/cleb_pkg.sv
// ----------------------------------------------------------------------------
// cleb_pkg
// Types and constants of the cursor line-edit buffer.
// ----------------------------------------------------------------------------
package cleb_pkg;

  localparam int unsigned CAPACITY_DEFAULT = 1024;

  typedef enum logic [2:0] {
    CMD_LEFT   = 3'd0,
    CMD_RIGHT  = 3'd1,
    CMD_DELETE = 3'd2,
    CMD_INSERT = 3'd3,
    CMD_READ   = 3'd4
  } cmd_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] char_in;
    logic [9:0] read_index;
  } cleb_in_t;

  typedef struct packed {
    logic [10:0] text_length;
    logic [10:0] cursor_pos;
    logic [7:0]  char_out;
    logic        refused;
  } cleb_out_t;

  typedef struct packed {
    logic launch;
    logic commit;
  } cleb_ctrl_t;

endpackage

>>> design/cleb_ram.sv
// ----------------------------------------------------------------------------
// cleb_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cleb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/cleb_ctrl.sv
// ----------------------------------------------------------------------------
// cleb_ctrl
// Command sequencer: accept a beat, run the execute state, strobe the result.
// ----------------------------------------------------------------------------
module cleb_ctrl import cleb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  output logic       done_o,
  output cleb_ctrl_t ctrl_o
);

  state_e state_q, state_d;
  logic   done_q, done_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    busy_o = 1'b0;
    done_d = 1'b0;
    unique case (state_q)
      ST_IDLE: ctrl_o.launch = start_i;
      ST_EXEC: begin
        busy_o        = 1'b1;
        ctrl_o.commit = 1'b1;
        done_d        = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign done_o = done_q;

endmodule

>>> design/cleb_dp.sv
// ----------------------------------------------------------------------------
// cleb_dp
// Gap-buffer datapath: text left of the cursor sits at the bottom of the
// store, text right of the cursor at the top; cursor moves shift one byte.
// ----------------------------------------------------------------------------
module cleb_dp import cleb_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cleb_ctrl_t ctrl_i,
  input  cleb_in_t   in_i,
  output cleb_out_t  result_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = CW + 11;

  logic [CW-1:0] len_q, len_d;
  logic [CW-1:0] cur_q, cur_d;
  logic [CW-1:0] tail_q, tail_d;
  logic [2:0]    cmd_q;
  logic [7:0]    ch_q;
  logic          hit_q;
  cleb_out_t     res_q;

  logic [XW-1:0] idx_x, len_x, cur_x, tail_x, map_x;
  logic [XW-1:0] len_dx, cur_dx;
  logic [AW-1:0] raddr;
  logic          hit;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic [7:0]    rdata;
  logic [7:0]    char_d;
  logic          refused_d;

  assign idx_x  = XW'(in_i.read_index);
  assign len_x  = XW'(len_q);
  assign cur_x  = XW'(cur_q);
  assign tail_x = XW'(tail_q);
  assign hit    = idx_x < len_x;
  assign map_x  = (idx_x < cur_x) ? idx_x : idx_x + (tail_x - cur_x);

  always_comb begin
    unique case (in_i.cmd)
      CMD_LEFT:  raddr = AW'(cur_x - XW'(1));
      CMD_RIGHT: raddr = AW'(tail_x);
      default:   raddr = AW'(map_x);
    endcase
  end

  cleb_ram #(
    .WIDTH (8),
    .DEPTH (CAPACITY)
  ) u_text_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (ctrl_i.launch),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    len_d     = len_q;
    cur_d     = cur_q;
    tail_d    = tail_q;
    we        = 1'b0;
    waddr     = AW'(cur_x);
    wdata     = rdata;
    char_d    = '0;
    refused_d = 1'b0;
    if (ctrl_i.commit) begin
      unique case (cmd_q)
        CMD_LEFT: begin
          if (cur_q != '0) begin
            we     = 1'b1;
            waddr  = AW'(tail_x - XW'(1));
            cur_d  = cur_q - CW'(1);
            tail_d = tail_q - CW'(1);
          end
        end
        CMD_RIGHT: begin
          if (cur_q != len_q) begin
            we     = 1'b1;
            cur_d  = cur_q + CW'(1);
            tail_d = tail_q + CW'(1);
          end
        end
        CMD_DELETE: begin
          if (cur_q != '0) begin
            cur_d = cur_q - CW'(1);
            len_d = len_q - CW'(1);
          end
        end
        CMD_INSERT: begin
          if (len_q == CW'(CAPACITY)) begin
            refused_d = 1'b1;
          end else begin
            we    = 1'b1;
            wdata = ch_q;
            cur_d = cur_q + CW'(1);
            len_d = len_q + CW'(1);
          end
        end
        CMD_READ: char_d = hit_q ? rdata : '0;
        default: ;
      endcase
    end
  end

  assign len_dx = XW'(len_d);
  assign cur_dx = XW'(cur_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      cur_q  <= '0;
      tail_q <= CW'(CAPACITY);
    end else begin
      len_q  <= len_d;
      cur_q  <= cur_d;
      tail_q <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.launch) begin
      cmd_q <= in_i.cmd;
      ch_q  <= in_i.char_in;
      hit_q <= hit;
    end
    if (ctrl_i.commit) begin
      res_q.text_length <= len_dx[10:0];
      res_q.cursor_pos  <= cur_dx[10:0];
      res_q.char_out    <= char_d;
      res_q.refused     <= refused_d;
    end
  end

  assign result_o = res_q;

endmodule

>>> design/cursor_line_edit_buffer.sv
// A command is accepted in idle and runs in the execute state; its result and done_o
// are registered at the end of that state. No new command is accepted while busy is high
// in the execute state, in which the text store read issued at accept returns and its write is made.
// The result is shown for one cycle on done_o and the receiver cannot stall.
// Reset clears length and cursor at once; the text store is not cleared.
// ----------------------------------------------------------------------------
// cursor_line_edit_buffer
// Gap-buffer line editor with cursor moves, delete, insert and indexed read.
// ----------------------------------------------------------------------------
`include "cursor_line_edit_buffer_macros.svh"

module cursor_line_edit_buffer import cleb_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  cleb_in_t  in_i,
  output logic      done_o,
  output cleb_out_t result_o
);

  cleb_ctrl_t ctrl;

  cleb_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .done_o  (done_o),
    .ctrl_o  (ctrl)
  );

  cleb_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .in_i     (in_i),
    .result_o (result_o)
  );

  `CLEB_ASSERT(a_launch_exec, ctrl.launch |=> ctrl.commit, "execute must follow accept")
  `CLEB_ASSERT(a_exec_done, ctrl.commit |=> done_o && !busy, "result strobe must follow execute")
  `CLEB_ASSERT_NEVER(a_launch_commit, ctrl.launch && ctrl.commit, "accept during execute")
  `CLEB_ASSERT(a_refused_insert, done_o && result_o.refused |-> $past(in_i.cmd, 2) == CMD_INSERT, "refusal without insert")

endmodule
